// File: rtl/assert_macros.svh
// Assertion macros used by the port checker of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent completes.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/aabb_pkg.sv
// Shared types and constants for the box collision test block.
// No dependencies; used by the top level and its port checker.
package aabb_pkg;

    // Coordinate format: signed Q16.16 in a COORD_BITS wide word.
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    // The plane distance enters the doubled test scaled to match Q32.32 products.
    localparam int DIST_SHIFT = FRAC_BITS + 1;

    localparam int CMD_BITS     = 3;
    localparam int CFG_IDX_BITS = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_BOX_OVERLAP  = 3'd0,
        CMD_SPHERE       = 3'd1,
        CMD_PLANE        = 3'd2,
        CMD_POINT_INSIDE = 3'd3,
        CMD_NEAREST      = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } cfg_reg_t;

endpackage

// File: rtl/aabb_collision_tests_unit.sv
// Throughput: one query per cycle while no stage is held; six register stages (clamp,
// differences, products, sums, magnitude and sphere compare, result) each take a new beat
// every cycle unless the result side stalls. A stalled result holds each stage from the
// output back to the first empty one; stages upstream of that bubble keep advancing.
// Reset clears all stage valid bits and sets every box bound to zero.
module aabb_collision_tests_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [aabb_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [aabb_pkg::COORD_BITS-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [aabb_pkg::CMD_BITS-1:0] cmd,
    input  aabb_pkg::coord_t              a_x,
    input  aabb_pkg::coord_t              a_y,
    input  aabb_pkg::coord_t              a_z,
    input  aabb_pkg::coord_t              b_x,
    input  aabb_pkg::coord_t              b_y,
    input  aabb_pkg::coord_t              b_z,
    input  aabb_pkg::coord_t              scalar,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output aabb_pkg::coord_t              near_x,
    output aabb_pkg::coord_t              near_y,
    output aabb_pkg::coord_t              near_z
);
    import aabb_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int EW = COORD_BITS + 1;      // widened difference or sum
    localparam int PW = 2 * COORD_BITS + 2;  // one product
    localparam int SW = PW + 2;              // sum of up to four products

    // Box bounds.
    coord_t box_min_reg [3];
    coord_t box_max_reg [3];

    // Configuration write decoder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                box_min_reg[i] <= '0;
                box_max_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_X: box_min_reg[0] <= coord_t'(cfg_data);
                REG_MIN_Y: box_min_reg[1] <= coord_t'(cfg_data);
                REG_MIN_Z: box_min_reg[2] <= coord_t'(cfg_data);
                REG_MAX_X: box_max_reg[0] <= coord_t'(cfg_data);
                REG_MAX_Y: box_max_reg[1] <= coord_t'(cfg_data);
                REG_MAX_Z: box_max_reg[2] <= coord_t'(cfg_data);
                default:   ;
            endcase
        end
    end

    // Stage valid bits and the ready chain, computed from the output backward.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

    assign rdy_out  = !out_valid_reg || !out_stall;
    assign rdy5     = !s5_valid_reg || rdy_out;
    assign rdy4     = !s4_valid_reg || rdy5;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (rdy5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (rdy_out)
            begin
                out_valid_reg <= s5_valid_reg;
            end
        end
    end

    // ---------------- Stage 1: clamp to the box and the bound compares.
    coord_t in_a [3];
    coord_t in_b [3];
    coord_t s1_near_next [3];
    logic   s1_box_next, s1_point_next;

    assign in_a[0] = a_x;
    assign in_a[1] = a_y;
    assign in_a[2] = a_z;
    assign in_b[0] = b_x;
    assign in_b[1] = b_y;
    assign in_b[2] = b_z;

    always_comb
    begin
        coord_t t;
        s1_box_next   = 1'b1;
        s1_point_next = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            t = (in_a[i] < box_max_reg[i]) ? in_a[i] : box_max_reg[i];
            s1_near_next[i] = (box_min_reg[i] > t) ? box_min_reg[i] : t;
            s1_box_next   = s1_box_next && (box_min_reg[i] <= in_b[i])
                                        && (box_max_reg[i] >= in_a[i]);
            s1_point_next = s1_point_next && (in_a[i] > box_min_reg[i])
                                          && (in_a[i] < box_max_reg[i]);
        end
    end

    logic [CMD_BITS-1:0] s1_cmd_reg;
    coord_t              s1_a_reg [3];
    coord_t              s1_near_reg [3];
    coord_t              s1_sc_reg;
    logic                s1_box_reg, s1_point_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_cmd_reg   <= cmd;
            s1_a_reg     <= in_a;
            s1_near_reg  <= s1_near_next;
            s1_sc_reg    <= scalar;
            s1_box_reg   <= s1_box_next;
            s1_point_reg <= s1_point_next;
        end
    end

    // ---------------- Stage 2: offsets from the nearest point, box center and extent terms.
    logic signed [EW-1:0] s2_d_next [3];
    logic signed [EW-1:0] s2_sum_next [3];
    logic signed [EW-1:0] s2_diff_next [3];
    logic signed [EW-1:0] s2_abs_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_d_next[i]    = EW'(s1_a_reg[i]) - EW'(s1_near_reg[i]);
            s2_sum_next[i]  = EW'(box_max_reg[i]) + EW'(box_min_reg[i]);
            s2_diff_next[i] = EW'(box_max_reg[i]) - EW'(box_min_reg[i]);
            s2_abs_next[i]  = s1_a_reg[i][CW-1] ? -EW'(s1_a_reg[i]) : EW'(s1_a_reg[i]);
        end
    end

    logic [CMD_BITS-1:0]  s2_cmd_reg;
    coord_t               s2_a_reg [3];
    coord_t               s2_near_reg [3];
    coord_t               s2_sc_reg;
    logic                 s2_box_reg, s2_point_reg;
    logic signed [EW-1:0] s2_d_reg [3];
    logic signed [EW-1:0] s2_sum_reg [3];
    logic signed [EW-1:0] s2_diff_reg [3];
    logic signed [EW-1:0] s2_abs_reg [3];

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_cmd_reg   <= s1_cmd_reg;
            s2_a_reg     <= s1_a_reg;
            s2_near_reg  <= s1_near_reg;
            s2_sc_reg    <= s1_sc_reg;
            s2_box_reg   <= s1_box_reg;
            s2_point_reg <= s1_point_reg;
            s2_d_reg     <= s2_d_next;
            s2_sum_reg   <= s2_sum_next;
            s2_diff_reg  <= s2_diff_next;
            s2_abs_reg   <= s2_abs_next;
        end
    end

    // ---------------- Stage 3: all products, one multiplier per term.
    logic signed [PW-1:0] s3_sq_next [3];
    logic signed [PW-1:0] s3_pm_next [3];
    logic signed [PW-1:0] s3_pe_next [3];
    logic signed [PW-1:0] s3_rr_next;
    logic signed [SW-1:0] s3_dterm_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_sq_next[i] = PW'(s2_d_reg[i]) * PW'(s2_d_reg[i]);
            s3_pm_next[i] = PW'(s2_a_reg[i]) * PW'(s2_sum_reg[i]);
            s3_pe_next[i] = PW'(s2_diff_reg[i]) * PW'(s2_abs_reg[i]);
        end
        s3_rr_next    = PW'(s2_sc_reg) * PW'(s2_sc_reg);
        s3_dterm_next = -(SW'(s2_sc_reg) <<< DIST_SHIFT);
    end

    logic [CMD_BITS-1:0]  s3_cmd_reg;
    coord_t               s3_near_reg [3];
    logic                 s3_box_reg, s3_point_reg, s3_sc_ok_reg;
    logic signed [PW-1:0] s3_sq_reg [3];
    logic signed [PW-1:0] s3_pm_reg [3];
    logic signed [PW-1:0] s3_pe_reg [3];
    logic signed [PW-1:0] s3_rr_reg;
    logic signed [SW-1:0] s3_dterm_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_cmd_reg   <= s2_cmd_reg;
            s3_near_reg  <= s2_near_reg;
            s3_box_reg   <= s2_box_reg;
            s3_point_reg <= s2_point_reg;
            s3_sc_ok_reg <= !s2_sc_reg[CW-1];
            s3_sq_reg    <= s3_sq_next;
            s3_pm_reg    <= s3_pm_next;
            s3_pe_reg    <= s3_pe_next;
            s3_rr_reg    <= s3_rr_next;
            s3_dterm_reg <= s3_dterm_next;
        end
    end

    // ---------------- Stage 4: sum the products per test.
    logic signed [SW-1:0] s4_d2_next, s4_s_next, s4_r_next;

    always_comb
    begin
        s4_d2_next = SW'(s3_sq_reg[0]) + SW'(s3_sq_reg[1]) + SW'(s3_sq_reg[2]);
        s4_s_next  = SW'(s3_pm_reg[0]) + SW'(s3_pm_reg[1]) + SW'(s3_pm_reg[2])
                   + s3_dterm_reg;
        s4_r_next  = SW'(s3_pe_reg[0]) + SW'(s3_pe_reg[1]) + SW'(s3_pe_reg[2]);
    end

    logic [CMD_BITS-1:0]  s4_cmd_reg;
    coord_t               s4_near_reg [3];
    logic                 s4_box_reg, s4_point_reg, s4_sc_ok_reg;
    logic signed [SW-1:0] s4_d2_reg, s4_s_reg, s4_r_reg;
    logic signed [PW-1:0] s4_rr_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_cmd_reg   <= s3_cmd_reg;
            s4_near_reg  <= s3_near_reg;
            s4_box_reg   <= s3_box_reg;
            s4_point_reg <= s3_point_reg;
            s4_sc_ok_reg <= s3_sc_ok_reg;
            s4_d2_reg    <= s4_d2_next;
            s4_s_reg     <= s4_s_next;
            s4_r_reg     <= s4_r_next;
            s4_rr_reg    <= s3_rr_reg;
        end
    end

    // ---------------- Stage 5: plane magnitude and the sphere compare.
    logic signed [SW-1:0] s5_abs_s_next;
    logic                 s5_sphere_next;

    assign s5_abs_s_next  = s4_s_reg[SW-1] ? -s4_s_reg : s4_s_reg;
    assign s5_sphere_next = s4_sc_ok_reg && (s4_d2_reg <= SW'(s4_rr_reg));

    logic [CMD_BITS-1:0]  s5_cmd_reg;
    coord_t               s5_near_reg [3];
    logic                 s5_box_reg, s5_point_reg, s5_sphere_reg;
    logic signed [SW-1:0] s5_abs_s_reg, s5_r_reg;

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            s5_cmd_reg    <= s4_cmd_reg;
            s5_near_reg   <= s4_near_reg;
            s5_box_reg    <= s4_box_reg;
            s5_point_reg  <= s4_point_reg;
            s5_sphere_reg <= s5_sphere_next;
            s5_abs_s_reg  <= s5_abs_s_next;
            s5_r_reg      <= s4_r_reg;
        end
    end

    // ---------------- Output stage: plane compare and selection by command.
    logic   hit_next;
    logic   hit_reg;
    coord_t near_reg [3];

    always_comb
    begin
        case (cmd_t'(s5_cmd_reg))
            CMD_BOX_OVERLAP:  hit_next = s5_box_reg;
            CMD_SPHERE:       hit_next = s5_sphere_reg;
            CMD_PLANE:        hit_next = (s5_abs_s_reg <= s5_r_reg);
            CMD_POINT_INSIDE: hit_next = s5_point_reg;
            default:          hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            hit_reg  <= hit_next;
            near_reg <= s5_near_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign near_x    = near_reg[0];
    assign near_y    = near_reg[1];
    assign near_z    = near_reg[2];

endmodule

// File: rtl/aabb_checker.sv
// Port-level checker for the box collision test block, bound to its top level.
// Depends on aabb_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module aabb_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [aabb_pkg::CMD_BITS-1:0] cmd,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          hit,
    input  aabb_pkg::coord_t              near_x,
    input  aabb_pkg::coord_t              near_y,
    input  aabb_pkg::coord_t              near_z
);
    import aabb_pkg::*;

    logic                       in_beat;
    logic                       nearest_beat;
    logic [3*COORD_BITS:0]      result_bits;

    assign in_beat      = in_valid && !in_stall;
    assign nearest_beat = in_beat && (cmd == CMD_NEAREST);
    assign result_bits  = {hit, near_x, near_y, near_z};

    // A stalled result beat stays presented.
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped under stall")

    // A stalled result beat keeps its payload.
    `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(result_bits), "result changed")

    // With the output free, an accepted query reaches the output without waiting in any stage.
    `ASSERT_NEXT(a_latency, in_beat ##1 (!out_stall) [*5], out_valid, "result was late")

    // The nearest-point query never reports a hit.
    `ASSERT_NEXT(a_nearest_no_hit, nearest_beat ##1 (!out_stall) [*5], !hit, "nearest hit")

endmodule

bind aabb_collision_tests_unit aabb_checker u_aabb_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for aabb_collision_tests_unit: box overlap, sphere, plane,
// point containment and nearest-point queries against boxes set up over the config port.
// Depends on rtl/aabb_pkg.sv and the unit itself; expected results come from a scoreboard.
module tb_top;
    import aabb_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        coord_t              a_x;
        coord_t              a_y;
        coord_t              a_z;
        coord_t              b_x;
        coord_t              b_y;
        coord_t              b_z;
        coord_t              scalar;
    } query_t;

    typedef struct packed {
        logic   hit;
        coord_t near_x;
        coord_t near_y;
        coord_t near_z;
    } result_t;

    localparam coord_t COORD_MIN = 32'sh8000_0000;
    localparam coord_t COORD_MAX = 32'sh7fff_ffff;
    localparam coord_t ONE = 32'sh0001_0000;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED_HI = 3'd7;
    localparam wide_t DIST_SCALE = 128'sd1 <<< DIST_SHIFT;
    localparam int SPREAD = 1 << 18;
    localparam int PIPE_SETTLE = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [COORD_BITS-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [CMD_BITS-1:0]     cmd = '0;
    coord_t                  a_x = '0;
    coord_t                  a_y = '0;
    coord_t                  a_z = '0;
    coord_t                  b_x = '0;
    coord_t                  b_y = '0;
    coord_t                  b_z = '0;
    coord_t                  scalar = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    hit;
    coord_t                  near_x;
    coord_t                  near_y;
    coord_t                  near_z;

    // Current box as the stimulus sees it, and the idling knobs of both sides.
    coord_t cur_lo[3] = '{'0, '0, '0};
    coord_t cur_hi[3] = '{'0, '0, '0};
    int     tx_max_gap = 0;
    int     rx_max_gap = 0;
    int     hold_cycles = 0;
    int     box_settings = 1;
    int     quiet_cycles = 0;

    // Holds the box mirror, predicts each query result and checks the result beats.
    class aabb_result_board;
        coord_t  box_lo[3];
        coord_t  box_hi[3];
        result_t expected_hits[$];
        int      errors;
        int      queries;
        int      results;
        int      hits[8];

        function new();
            for (int k = 0; k < 3; k++)
            begin
                box_lo[k] = '0;
                box_hi[k] = '0;
            end
            errors = 0;
            queries = 0;
            results = 0;
            for (int k = 0; k < 8; k++)
                hits[k] = 0;
        endfunction

        function void set_bound(cfg_reg_t idx, coord_t value);
            case (idx)
                REG_MIN_X: box_lo[0] = value;
                REG_MIN_Y: box_lo[1] = value;
                REG_MIN_Z: box_lo[2] = value;
                REG_MAX_X: box_hi[0] = value;
                REG_MAX_Y: box_hi[1] = value;
                REG_MAX_Z: box_hi[2] = value;
                default: ;
            endcase
        endfunction

        function coord_t clamp_axis(coord_t p, coord_t lo, coord_t hi);
            coord_t t;
            t = (p < hi) ? p : hi;
            return (lo > t) ? lo : t;
        endfunction

        // Exact geometric tests in 128-bit arithmetic; the plane test uses the doubled form.
        function result_t predict_hit(query_t q);
            coord_t  pa[3];
            coord_t  pb[3];
            coord_t  pn[3];
            coord_t  rad;
            wide_t   d;
            wide_t   dist2;
            wide_t   rad2;
            wide_t   centre;
            wide_t   extent;
            wide_t   mag;
            logic    overlap;
            logic    contained;
            result_t r;
            pa = '{q.a_x, q.a_y, q.a_z};
            pb = '{q.b_x, q.b_y, q.b_z};
            rad = q.scalar;
            dist2 = '0;
            extent = '0;
            centre = -(wide_t'(rad) * DIST_SCALE);
            overlap = 1'b1;
            contained = 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                pn[k] = clamp_axis(pa[k], box_lo[k], box_hi[k]);
                d = wide_t'(pa[k]) - wide_t'(pn[k]);
                dist2 = dist2 + d * d;
                centre = centre + wide_t'(pa[k]) * (wide_t'(box_hi[k]) + wide_t'(box_lo[k]));
                mag = (pa[k] < 0) ? -wide_t'(pa[k]) : wide_t'(pa[k]);
                extent = extent + (wide_t'(box_hi[k]) - wide_t'(box_lo[k])) * mag;
                if (!(box_lo[k] <= pb[k] && box_hi[k] >= pa[k]))
                    overlap = 1'b0;
                if (!(pa[k] > box_lo[k] && pa[k] < box_hi[k]))
                    contained = 1'b0;
            end
            rad2 = wide_t'(rad) * wide_t'(rad);
            mag = (centre < 0) ? -centre : centre;
            case (q.cmd)
                CMD_BOX_OVERLAP:  r.hit = overlap;
                CMD_SPHERE:       r.hit = (rad >= 0) && (dist2 <= rad2);
                CMD_PLANE:        r.hit = (mag <= extent);
                CMD_POINT_INSIDE: r.hit = contained;
                default:          r.hit = 1'b0;
            endcase
            r.near_x = pn[0];
            r.near_y = pn[1];
            r.near_z = pn[2];
            return r;
        endfunction

        function void note_query(query_t q);
            result_t r;
            r = predict_hit(q);
            expected_hits.push_back(r);
            queries++;
            hits[q.cmd] += r.hit;
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction

        function void compare_field(string name, coord_t want, coord_t got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            results++;
            if (expected_hits.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with no query outstanding, expected none, got hit %0b",
                         $time, got.hit);
            end
            else
            begin
                want = expected_hits.pop_front();
                compare_field("hit", coord_t'(want.hit), coord_t'(got.hit));
                compare_field("near_x", want.near_x, got.near_x);
                compare_field("near_y", want.near_y, got.near_y);
                compare_field("near_z", want.near_z, got.near_z);
            end
        endfunction
    endclass

    aabb_result_board sb;

    always #1 clk = ~clk;

    aabb_collision_tests_unit i_dut (.*);

    // Mirror config writes and record every accepted beat on both channels.
    always @(posedge clk)
    begin : beat_monitor
        query_t  seen_q;
        result_t seen_r;
        if (rst_n)
        begin
            if (cfg_we)
                sb.set_bound(cfg_reg_t'(cfg_index), cfg_data);
            if (in_valid && !in_stall)
            begin
                seen_q.cmd = cmd;
                seen_q.a_x = a_x;
                seen_q.a_y = a_y;
                seen_q.a_z = a_z;
                seen_q.b_x = b_x;
                seen_q.b_y = b_y;
                seen_q.b_z = b_z;
                seen_q.scalar = scalar;
                sb.note_query(seen_q);
            end
            if (out_valid && !out_stall)
            begin
                seen_r.hit = hit;
                seen_r.near_x = near_x;
                seen_r.near_y = near_y;
                seen_r.near_z = near_z;
                sb.check_result(seen_r);
            end
        end
    end

    // Give up when nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stalls per beat, plus a long hold-off when requested.
    initial
    begin : result_sink
        int n;
        wait (rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            n = (rx_max_gap > 0) ? $urandom_range(0, rx_max_gap) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    function automatic coord_t q16(int whole);
        return coord_t'(whole * (1 << FRAC_BITS));
    endfunction

    function automatic coord_t jitter();
        return coord_t'($urandom_range(0, 2 * SPREAD)) - coord_t'(SPREAD);
    endfunction

    // Coordinates biased toward the box faces and the extremes of the field.
    function automatic coord_t pick_coord(coord_t lo, coord_t hi);
        coord_t v;
        case ($urandom_range(0, 9))
            0, 1: v = coord_t'($urandom);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = COORD_MIN;
                    1: v = COORD_MAX;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            3: v = lo;
            4: v = hi;
            5, 6: v = lo + jitter();
            7: v = hi + jitter();
            default: v = coord_t'((longint'(lo) + longint'(hi)) >>> 1) + jitter();
        endcase
        return v;
    endfunction

    function automatic query_t random_query();
        query_t q;
        coord_t pa[3];
        coord_t pb[3];
        longint proj;
        if ($urandom_range(0, 15) == 0)
            q.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        else
            q.cmd = 3'($urandom_range(CMD_BOX_OVERLAP, CMD_NEAREST));
        for (int k = 0; k < 3; k++)
        begin
            pa[k] = pick_coord(cur_lo[k], cur_hi[k]);
            pb[k] = pick_coord(cur_lo[k], cur_hi[k]);
        end
        q.scalar = coord_t'($urandom);
        if (q.cmd == CMD_SPHERE && $urandom_range(0, 7) != 0)
            q.scalar = coord_t'($urandom_range(0, 4 * SPREAD));
        // Half the planes get short normals; most get a distance near the box centre.
        if (q.cmd == CMD_PLANE)
        begin
            if ($urandom_range(0, 1) == 1)
                for (int k = 0; k < 3; k++)
                    pa[k] = jitter();
            if ($urandom_range(0, 3) != 0)
            begin
                proj = 0;
                for (int k = 0; k < 3; k++)
                    proj += longint'(pa[k]) * ((longint'(cur_lo[k]) + longint'(cur_hi[k])) >>> 1);
                q.scalar = coord_t'(proj >>> FRAC_BITS) + jitter();
            end
        end
        q.a_x = pa[0];
        q.a_y = pa[1];
        q.a_z = pa[2];
        q.b_x = pb[0];
        q.b_y = pb[1];
        q.b_z = pb[2];
        return q;
    endfunction

    // Offer one query beat after a random gap and hold it until it is taken.
    task automatic send_query(query_t q);
        int gap;
        gap = (tx_max_gap > 0) ? $urandom_range(0, tx_max_gap) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= q.cmd;
        a_x <= q.a_x;
        a_y <= q.a_y;
        a_z <= q.a_z;
        b_x <= q.b_x;
        b_y <= q.b_y;
        b_z <= q.b_z;
        scalar <= q.scalar;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_fields(logic [CMD_BITS-1:0] op, coord_t ax, coord_t ay, coord_t az,
                               coord_t bx, coord_t by, coord_t bz, coord_t sc);
        query_t q;
        q = '{op, ax, ay, az, bx, by, bz, sc};
        send_query(q);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, coord_t value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // Write the box held in cur_lo and cur_hi; only called with the unit idle.
    task automatic load_box();
        write_reg(REG_MIN_X, cur_lo[0]);
        write_reg(REG_MIN_Y, cur_lo[1]);
        write_reg(REG_MIN_Z, cur_lo[2]);
        write_reg(REG_MAX_X, cur_hi[0]);
        write_reg(REG_MAX_Y, cur_hi[1]);
        write_reg(REG_MAX_Z, cur_hi[2]);
        cfg_we <= 1'b0;
        box_settings++;
    endtask

    task automatic run_phase(int count, int tx_gap, int rx_gap, int hold);
        tx_max_gap = tx_gap;
        rx_max_gap = rx_gap;
        hold_cycles = hold;
        repeat (count) send_query(random_query());
        wait_idle();
    endtask

    initial
    begin : stimulus
        coord_t t;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the zero box left by reset.
        tx_max_gap = 0;
        rx_max_gap = 2;
        send_fields(CMD_BOX_OVERLAP, -ONE, -ONE, -ONE, ONE, ONE, ONE, 0);
        send_fields(CMD_POINT_INSIDE, 0, 0, 0, 0, 0, 0, 0);
        send_fields(CMD_SPHERE, ONE, 0, 0, 0, 0, 0, ONE);
        wait_idle();

        // Directed: a regular box, touching cases on both sides of each inequality.
        cur_lo = '{q16(-2), q16(-1), q16(0)};
        cur_hi = '{q16(3), q16(4), q16(5)};
        load_box();
        send_fields(CMD_BOX_OVERLAP, -ONE, 0, ONE, ONE, q16(2), q16(3), 0);
        send_fields(CMD_BOX_OVERLAP, q16(3), q16(4), q16(5), q16(6), q16(6), q16(6), 0);
        send_fields(CMD_BOX_OVERLAP, q16(3) + 1, 0, 0, q16(6), ONE, ONE, 0);
        send_fields(CMD_BOX_OVERLAP, q16(-6), q16(-6), q16(-6), q16(-2), -ONE, 0, 0);
        send_fields(CMD_SPHERE, q16(5), ONE, ONE, 0, 0, 0, q16(2));
        send_fields(CMD_SPHERE, q16(5), ONE, ONE, 0, 0, 0, q16(2) - 1);
        send_fields(CMD_SPHERE, 0, 0, ONE, 0, 0, 0, -ONE);
        send_fields(CMD_SPHERE, q16(6), q16(7), q16(8), 0, 0, 0, q16(6));
        send_fields(CMD_PLANE, ONE, 0, 0, 0, 0, 0, q16(3));
        send_fields(CMD_PLANE, ONE, 0, 0, 0, 0, 0, q16(3) + 1);
        send_fields(CMD_PLANE, ONE, ONE, ONE, 0, 0, 0, 0);
        send_fields(CMD_PLANE, 0, 0, -ONE, 0, 0, 0, 0);
        send_fields(CMD_POINT_INSIDE, 0, 0, ONE, 0, 0, 0, 0);
        send_fields(CMD_POINT_INSIDE, q16(3), 0, ONE, 0, 0, 0, 0);
        send_fields(CMD_POINT_INSIDE, q16(-2), 0, ONE, 0, 0, 0, 0);
        send_fields(CMD_NEAREST, q16(-10), q16(10), q16(2), 0, 0, 0, 0);
        send_fields(CMD_UNUSED_LO, q16(100), q16(-100), q16(3), 0, 0, 0, 0);
        send_fields(CMD_UNUSED_HI, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                    COORD_MAX, COORD_MAX);
        send_fields(CMD_NEAREST, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                    COORD_MIN, COORD_MIN);
        send_fields(CMD_SPHERE, COORD_MAX, COORD_MIN, COORD_MAX, 0, 0, 0, COORD_MAX);
        send_fields(CMD_PLANE, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, COORD_MIN);
        send_fields(CMD_BOX_OVERLAP, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                    COORD_MAX, 0);
        wait_idle();

        // Directed: a box inverted on x and z.
        cur_lo = '{q16(4), q16(-2), q16(7)};
        cur_hi = '{q16(-4), q16(6), q16(1)};
        load_box();
        send_fields(CMD_NEAREST, q16(10), q16(10), q16(10), 0, 0, 0, 0);
        send_fields(CMD_BOX_OVERLAP, q16(-10), q16(-10), q16(-10), q16(10), q16(10), q16(10), 0);
        send_fields(CMD_PLANE, ONE, 0, 0, 0, 0, 0, 0);
        send_fields(CMD_POINT_INSIDE, 0, 0, q16(4), 0, 0, 0, 0);
        wait_idle();

        // Random: regular box, back-to-back beats and one long result hold-off.
        cur_lo = '{q16(-5), q16(-3), -ONE};
        cur_hi = '{q16(4), q16(6), q16(2) + (ONE >>> 1)};
        load_box();
        run_phase(160, 0, 0, HOLD_CYCLES);

        // Random: the widest box the format allows.
        cur_lo = '{COORD_MIN, COORD_MIN, COORD_MIN};
        cur_hi = '{COORD_MAX, COORD_MAX, COORD_MAX};
        load_box();
        run_phase(150, 8, 0, 0);

        // Random: inverted box.
        cur_lo = '{q16(4), q16(-2), q16(7)};
        cur_hi = '{q16(-4), q16(6), q16(1)};
        load_box();
        run_phase(150, 0, 8, 0);

        // Random: flat box, min equal to max on every axis.
        for (int k = 0; k < 3; k++)
        begin
            cur_lo[k] = jitter();
            cur_hi[k] = cur_lo[k];
        end
        load_box();
        run_phase(140, 8, 8, 0);

        // Random: arbitrary corners, ordered.
        for (int k = 0; k < 3; k++)
        begin
            cur_lo[k] = coord_t'($urandom);
            cur_hi[k] = coord_t'($urandom);
            if (cur_lo[k] > cur_hi[k])
            begin
                t = cur_lo[k];
                cur_lo[k] = cur_hi[k];
                cur_hi[k] = t;
            end
        end
        load_box();
        run_phase(150, 8, 8, 0);

        // Random: arbitrary corners, left unordered.
        for (int k = 0; k < 3; k++)
        begin
            cur_lo[k] = coord_t'($urandom);
            cur_hi[k] = coord_t'($urandom);
        end
        load_box();
        run_phase(150, 4, 4, 0);

        $display("Checked %0d results for %0d queries over %0d box settings.",
                 sb.results, sb.queries, box_settings);
        $display("Hits: overlap %0d, sphere %0d, plane %0d, point inside %0d.",
                 sb.hits[CMD_BOX_OVERLAP], sb.hits[CMD_SPHERE], sb.hits[CMD_PLANE],
                 sb.hits[CMD_POINT_INSIDE]);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: aabb_collision_tests_unit.f
+incdir+rtl
rtl/aabb_pkg.sv
rtl/aabb_collision_tests_unit.sv
rtl/aabb_checker.sv
sim/tb_top.sv
